// ===== rtl/core/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the polygon clipper
// Vertex type, configuration register indexes, clip edge codes and the
// request bundle of the crossing divider.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int RPC_MAX_VERTS = 24;
	localparam int COORD_W       = 24;
	localparam int LIMIT_W       = 16;
	localparam int CFG_IDX_W     = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_LIMIT = 3'd4;

	// clip edges in pass order
	localparam logic [1:0] EDGE_TOP    = 2'd0;
	localparam logic [1:0] EDGE_RIGHT  = 2'd1;
	localparam logic [1:0] EDGE_BOTTOM = 2'd2;
	localparam logic [1:0] EDGE_LEFT   = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	// result = base + round_half_up(fa * fb / den)
	typedef struct packed {
		logic signed [COORD_W:0]   fa;
		logic signed [COORD_W:0]   fb;
		logic signed [COORD_W:0]   den;
		logic signed [COORD_W-1:0] base;
	} div_req_t;

endpackage

// ===== rtl/core/rpc_cell.sv =====
// ----------------------------------------------------------------------------
// rpc_cell: one vertex cell of a shifting vertex chain
// Loads a pushed vertex or takes its neighbor's vertex on a shift.
// ----------------------------------------------------------------------------
module rpc_cell
	import rpc_pkg::*;
(
	input  logic   clk,
	input  logic   shift,
	input  logic   load,
	input  point_t nxt,
	input  point_t ld_data,
	output point_t val
);

	point_t val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= ld_data;
		end else if (shift) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule

// ===== rtl/core/rpc_chain.sv =====
// ----------------------------------------------------------------------------
// rpc_chain: vertex FIFO built as a row of shifting cells
// Push writes the cell at the fill position, pop shifts every cell one place
// toward the head. Never pushed and popped in the same cycle.
// ----------------------------------------------------------------------------
module rpc_chain
	import rpc_pkg::*;
#(
	parameter int DEPTH = 2 * RPC_MAX_VERTS
)(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           pop,
	input  point_t                         push_data,
	output point_t                         head,
	output point_t                         last,
	output logic                           full,
	output logic [$clog2(DEPTH+1)-1:0]     cnt
);

	localparam int CNTW = $clog2(DEPTH + 1);

	logic [CNTW-1:0] cnt_q;
	point_t          last_q;
	point_t          val [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		point_t nxt_i;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt_i = push_data;
		end else begin : g_mid
			assign nxt_i = val[i+1];
		end
		rpc_cell u_cell (
			.clk    (clk),
			.shift  (pop),
			.load   (push && (cnt_q == CNTW'(i))),
			.nxt    (nxt_i),
			.ld_data(push_data),
			.val    (val[i])
		);
	end

	assign full = (cnt_q == CNTW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push && !full) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (pop && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			last_q <= push_data;
		end
	end

	assign head = val[0];
	assign last = last_q;
	assign cnt  = cnt_q;

endmodule

// ===== rtl/core/rpc_div.sv =====
// ----------------------------------------------------------------------------
// rpc_div: crossing coordinate unit
// Multiplies, then divides one quotient bit per cycle and rounds half up:
// res = base + floor(fa*fb/den + 1/2).
// ----------------------------------------------------------------------------
module rpc_div
	import rpc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  div_req_t                  req,
	output logic                      done,
	output logic signed [COORD_W-1:0] res
);

	localparam int PW = 2 * (COORD_W + 1);  // product width
	localparam int NW = PW + 2;             // |2*num + den| width
	localparam int DW = COORD_W + 2;        // 2*|den| width
	localparam int IW = $clog2(NW);

	typedef enum logic [6:0] {
		D_IDLE = 7'b0000001,
		D_MUL  = 7'b0000010,
		D_ADJ  = 7'b0000100,
		D_SUM  = 7'b0001000,
		D_ABS  = 7'b0010000,
		D_RUN  = 7'b0100000,
		D_FIN  = 7'b1000000
	} dstate_t;

	dstate_t                  st_q;
	div_req_t                 req_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [PW:0]       numa_q;
	logic [COORD_W:0]         dpos_q;
	logic signed [NW:0]       nsum_q;
	logic                     neg_q;
	logic [NW-1:0]            nq_q;
	logic [DW-1:0]            rem_q;
	logic [IW-1:0]            it_q;
	logic                     done_q;
	logic signed [COORD_W-1:0] res_q;

	logic [DW:0]              trial;
	logic [DW:0]              dvs;
	logic                     fit;
	logic [COORD_W-1:0]       q24;
	logic [COORD_W-1:0]       qv;

	always_comb begin
		trial = {rem_q, nq_q[NW-1]};
		dvs   = {1'b0, dpos_q, 1'b0};
		fit   = (trial >= dvs);
		// floor of a negative quotient steps down when there is a remainder
		q24   = nq_q[COORD_W-1:0] + COORD_W'(neg_q && (rem_q != '0));
		qv    = neg_q ? (~q24 + 1'b1) : q24;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: if (start) st_q <= D_MUL;
				D_MUL:  st_q <= D_ADJ;
				D_ADJ:  st_q <= D_SUM;
				D_SUM:  st_q <= D_ABS;
				D_ABS:  st_q <= D_RUN;
				D_RUN:  if (it_q == '0) st_q <= D_FIN;
				D_FIN: begin
					done_q <= 1'b1;
					st_q   <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: if (start) req_q <= req;
			D_MUL:  prod_q <= req_q.fa * req_q.fb;
			D_ADJ: begin
				// make the divisor positive
				numa_q <= req_q.den[COORD_W] ? -((PW+1)'(prod_q)) : (PW+1)'(prod_q);
				dpos_q <= req_q.den[COORD_W] ? (COORD_W+1)'(-req_q.den)
				                             : (COORD_W+1)'(req_q.den);
			end
			D_SUM:  nsum_q <= ((NW+1)'(numa_q) <<< 1) + $signed({(NW-COORD_W)'(0), dpos_q});
			D_ABS: begin
				neg_q <= nsum_q[NW];
				nq_q  <= nsum_q[NW] ? NW'(-nsum_q) : nsum_q[NW-1:0];
				rem_q <= '0;
				it_q  <= IW'(NW - 1);
			end
			D_RUN: begin
				rem_q <= fit ? DW'(trial - dvs) : trial[DW-1:0];
				nq_q  <= {nq_q[NW-2:0], fit};
				it_q  <= it_q - 1'b1;
			end
			D_FIN:  res_q <= req_q.base + $signed(qv);
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/core/polygon_rect_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// polygon_rect_clipper_unit: clips one polygon against a rectangular window
// Vertices come in on the input channel (in_valid/in_ready), one per request;
// last_vertex ends the polygon. Up to MAX_VERTS vertices are kept, more are
// dropped and flagged. The window and bypass limit are written through the
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data); the user must write
// them only while idle, the block itself does not enforce it. After the last
// vertex a small polygon is sent back unchanged, one vertex per cycle while
// the receiver takes them; otherwise four clip passes run over the vertex
// chains and every boundary crossing waits on the shared crossing divider.
// Results leave on the out channel (out_valid/out_ready) through an output
// register; a stalled receiver holds the emission, and the next polygon may
// be collected while the final result still waits.
// Reset empties both chains, restores the register defaults and leaves the
// block ready for a first vertex; no clearing pass is needed.
// ----------------------------------------------------------------------------
module polygon_rect_clipper_unit
	import rpc_pkg::*;
#(
	parameter int MAX_VERTS = RPC_MAX_VERTS
)(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_W-1:0]         cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COORD_W-1:0]  vertex_x,
	input  logic signed [COORD_W-1:0]  vertex_y,
	input  logic                       last_vertex,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  out_x,
	output logic signed [COORD_W-1:0]  out_y,
	output logic                       out_last,
	output logic                       empty_result,
	output logic                       bypassed,
	output logic                       overflowed
);

	localparam int DEPTH = 2 * MAX_VERTS;
	localparam int CNTW  = $clog2(DEPTH + 1);

	typedef enum logic [7:0] {
		S_COLLECT = 8'b00000001,
		S_DECIDE  = 8'b00000010,
		S_PSTART  = 8'b00000100,
		S_STEP    = 8'b00001000,
		S_DIV     = 8'b00010000,
		S_PUSHP   = 8'b00100000,
		S_PEND    = 8'b01000000,
		S_EMIT    = 8'b10000000
	} state_t;

	state_t                    state_q;
	logic signed [COORD_W-1:0] left_q, top_q, right_q, bottom_q;
	logic [LIMIT_W-1:0]        limit_q;
	logic [31:0]               spread_q;
	logic                      ovf_q, byp_q, empty_q, pushp_q, src_sel_q;
	logic [1:0]                edge_q;
	point_t                    s_q;

	logic                      out_valid_q, out_last_q, out_empty_q, out_byp_q, out_ovf_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;

	point_t          head_a, head_b, last_a, last_b, vin, p, xpt, push_pt;
	point_t          src_last;
	logic            full_a, full_b, dst_full;
	logic [CNTW-1:0] cnt_a, cnt_b, cnt_src;
	logic            push_a, push_b, pop_a, pop_b, push_d, pop_s;
	logic            in_acc, keep, ins_p, ins_s, can_load, div_start, div_done;
	logic signed [COORD_W-1:0] bnd, div_res;
	logic [COORD_W+1:0] man;
	logic [31:0]     lim_n;
	div_req_t        dreq;

	function automatic logic inside_edge(input logic [1:0] e, input point_t v,
		input logic signed [COORD_W-1:0] t, input logic signed [COORD_W-1:0] r,
		input logic signed [COORD_W-1:0] b, input logic signed [COORD_W-1:0] l);
		logic res;
		case (e)
			EDGE_TOP:    res = v.y > t;
			EDGE_RIGHT:  res = v.x < r;
			EDGE_BOTTOM: res = v.y < b;
			EDGE_LEFT:   res = v.x > l;
			default:     res = 1'b0;
		endcase
		return res;
	endfunction

	rpc_chain #(.DEPTH(DEPTH)) u_chain_a (
		.clk(clk), .arst_n(arst_n), .push(push_a), .pop(pop_a), .push_data(push_pt),
		.head(head_a), .last(last_a), .full(full_a), .cnt(cnt_a)
	);

	rpc_chain #(.DEPTH(DEPTH)) u_chain_b (
		.clk(clk), .arst_n(arst_n), .push(push_b), .pop(pop_b), .push_data(push_pt),
		.head(head_b), .last(last_b), .full(full_b), .cnt(cnt_b)
	);

	rpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .req(dreq),
		.done(div_done), .res(div_res)
	);

	always_comb begin
		vin.x    = vertex_x;
		vin.y    = vertex_y;
		in_acc   = in_valid && in_ready;
		keep     = (cnt_a < CNTW'(MAX_VERTS));
		p        = src_sel_q ? head_b : head_a;
		src_last = src_sel_q ? last_b : last_a;
		cnt_src  = src_sel_q ? cnt_b : cnt_a;
		dst_full = src_sel_q ? full_a : full_b;
		ins_p    = inside_edge(edge_q, p, top_q, right_q, bottom_q, left_q);
		ins_s    = inside_edge(edge_q, s_q, top_q, right_q, bottom_q, left_q);
		can_load = !out_valid_q || out_ready;
		lim_n    = 32'(limit_q * cnt_a);
		man      = (COORD_W+2)'(vin.x > head_a.x ? vin.x - head_a.x : head_a.x - vin.x)
		         + (COORD_W+2)'(vin.y > head_a.y ? vin.y - head_a.y : head_a.y - vin.y);

		// crossing against the current edge
		case (edge_q)
			EDGE_TOP:    bnd = top_q;
			EDGE_RIGHT:  bnd = right_q;
			EDGE_BOTTOM: bnd = bottom_q;
			EDGE_LEFT:   bnd = left_q;
			default:     bnd = top_q;
		endcase
		if (!edge_q[0]) begin
			dreq.fa   = (COORD_W+1)'(p.x) - (COORD_W+1)'(s_q.x);
			dreq.fb   = (COORD_W+1)'(bnd) - (COORD_W+1)'(s_q.y);
			dreq.den  = (COORD_W+1)'(p.y) - (COORD_W+1)'(s_q.y);
			dreq.base = s_q.x;
			xpt.x     = div_res;
			xpt.y     = bnd;
		end else begin
			dreq.fa   = (COORD_W+1)'(p.y) - (COORD_W+1)'(s_q.y);
			dreq.fb   = (COORD_W+1)'(bnd) - (COORD_W+1)'(s_q.x);
			dreq.den  = (COORD_W+1)'(p.x) - (COORD_W+1)'(s_q.x);
			dreq.base = s_q.y;
			xpt.x     = bnd;
			xpt.y     = div_res;
		end

		push_d    = 1'b0;
		pop_s     = 1'b0;
		div_start = 1'b0;
		push_pt   = p;
		pop_a     = 1'b0;
		push_a    = 1'b0;
		case (state_q)
			S_COLLECT: begin
				push_a  = in_acc && keep;
				push_pt = vin;
			end
			S_STEP: begin
				if (ins_p == ins_s) begin
					push_d = ins_p;
					pop_s  = 1'b1;
				end else begin
					div_start = 1'b1;
				end
			end
			S_DIV: begin
				push_pt = xpt;
				push_d  = div_done;
				pop_s   = div_done && !pushp_q;
			end
			S_PUSHP: begin
				push_d = 1'b1;
				pop_s  = 1'b1;
			end
			S_EMIT:  pop_a = can_load && !empty_q;
			default: ;
		endcase
		push_a = push_a || (push_d && src_sel_q);
		push_b = push_d && !src_sel_q;
		pop_a  = pop_a || (pop_s && !src_sel_q);
		pop_b  = pop_s && src_sel_q;
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_COLLECT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= COORD_W'(1023);
			bottom_q <= COORD_W'(767);
			limit_q  <= LIMIT_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CLIP_LEFT:    left_q   <= cfg_data;
				CFG_CLIP_TOP:     top_q    <= cfg_data;
				CFG_CLIP_RIGHT:   right_q  <= cfg_data;
				CFG_CLIP_BOTTOM:  bottom_q <= cfg_data;
				CFG_BYPASS_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			spread_q    <= '0;
			ovf_q       <= 1'b0;
			byp_q       <= 1'b0;
			empty_q     <= 1'b0;
			pushp_q     <= 1'b0;
			src_sel_q   <= 1'b0;
			edge_q      <= EDGE_TOP;
			out_valid_q <= 1'b0;
		end else begin
			if (push_d && dst_full) begin
				ovf_q <= 1'b1;
			end
			if (out_valid_q && out_ready && !(state_q == S_EMIT && can_load)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_COLLECT: begin
					if (in_acc) begin
						if (!keep) begin
							ovf_q <= 1'b1;
						end else if (cnt_a != '0) begin
							spread_q <= spread_q + 32'(man);
						end
						if (last_vertex) state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (spread_q < lim_n) begin
						byp_q   <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						edge_q    <= EDGE_TOP;
						src_sel_q <= 1'b0;
						state_q   <= S_PSTART;
					end
				end
				S_PSTART: begin
					s_q     <= src_last;
					state_q <= (cnt_src == '0) ? S_PEND : S_STEP;
				end
				S_STEP: begin
					if (ins_p == ins_s) begin
						s_q     <= p;
						state_q <= (cnt_src == CNTW'(1)) ? S_PEND : S_STEP;
					end else begin
						pushp_q <= ins_p;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (pushp_q) begin
							state_q <= S_PUSHP;
						end else begin
							s_q     <= p;
							state_q <= (cnt_src == CNTW'(1)) ? S_PEND : S_STEP;
						end
					end
				end
				S_PUSHP: begin
					s_q     <= p;
					state_q <= (cnt_src == CNTW'(1)) ? S_PEND : S_STEP;
				end
				S_PEND: begin
					if (edge_q == EDGE_LEFT) begin
						empty_q   <= (cnt_a == '0);
						src_sel_q <= 1'b0;
						state_q   <= S_EMIT;
					end else begin
						edge_q    <= edge_q + 1'b1;
						src_sel_q <= !src_sel_q;
						state_q   <= S_PSTART;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						if (empty_q || cnt_a == CNTW'(1)) begin
							state_q  <= S_COLLECT;
							spread_q <= '0;
							ovf_q    <= 1'b0;
							byp_q    <= 1'b0;
							empty_q  <= 1'b0;
						end
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && can_load) begin
			out_x_q     <= empty_q ? '0 : head_a.x;
			out_y_q     <= empty_q ? '0 : head_a.y;
			out_last_q  <= empty_q || (cnt_a == CNTW'(1));
			out_empty_q <= empty_q;
			out_byp_q   <= byp_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_last     = out_last_q;
	assign empty_result = out_empty_q;
	assign bypassed     = out_byp_q;
	assign overflowed   = out_ovf_q;

	// chain B only holds data during clip passes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COLLECT) |-> (cnt_b == '0))
		else $error("chain B not empty while collecting");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_result) |-> (out_last && !bypassed))
		else $error("empty result not a single final request");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("crossing result arrived outside divide wait");

endmodule
